// ===== hw/rtl/tcc_pkg.sv =====
package tcc_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic CFG_DISPLAY = 1'b0;
  localparam logic CFG_INDENT  = 1'b1;

  localparam logic [7:0] WIN_LEFT  = 8'd8;
  localparam logic [7:0] WIN_TOP   = 8'd28;
  localparam logic [7:0] CELL_W    = 8'd8;
  localparam logic [7:0] ROW_H     = 8'd16;
  localparam logic [7:0] TAB_MASK  = 8'h1f;

  // draw and scroll commands allowed ahead of the report
  localparam logic [2:0] BODY_MAX = 3'd5;
  // index of the last cell a tab draws, counted from zero
  localparam logic [2:0] TAB_LAST_CELL = 3'd7;

  typedef struct packed {
    logic load;
    logic draw;
    logic step;
    logic newline;
    logic report;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_lf;
    logic in_cr;
    logic tab;
    logic adv;
    logic tab_stop;
    logic out_free;
  } ctl_status_t;

endpackage

// ===== hw/rtl/tcc_in_if.sv =====
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       advance;

  modport source (output valid, output char_code, output advance, input ready);
  modport sink (input valid, input char_code, input advance, output ready);
endinterface

// ===== hw/rtl/tcc_out_if.sv =====
interface tcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] glyph;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic       last;

  modport source (output valid, output command, output glyph, output pos_x,
                  output pos_y, output last, input ready);
  modport sink (input valid, input command, input glyph, input pos_x,
                input pos_y, input last, output ready);
endinterface

// ===== hw/rtl/tcc_ctrl.sv =====
module tcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcc_pkg::ctl_status_t status,
  output tcc_pkg::ctl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DRAW   = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_NL     = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] cells;
  logic [2:0] cells_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cells_next = cells;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cells_next = '0;
          if (status.in_lf) state_next = S_NL;
          else if (status.in_cr) state_next = S_REPORT;
          else state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        if (status.out_free) begin
          cmd.draw = 1'b1;
          state_next = (status.tab || status.adv) ? S_STEP : S_REPORT;
        end
      end
      S_STEP: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.tab && !status.tab_stop && cells != tcc_pkg::TAB_LAST_CELL) begin
            cells_next = cells + 3'd1;
            state_next = S_DRAW;
          end else begin
            state_next = S_REPORT;
          end
        end
      end
      S_NL: begin
        if (status.out_free) begin
          cmd.newline = 1'b1;
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (status.out_free) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cells <= '0;
    end else begin
      state <= state_next;
      cells <= cells_next;
    end
  end

endmodule

// ===== hw/rtl/tcc_datapath.sv =====
module tcc_datapath #(
  parameter int TEXT_COLUMNS = 30,
  parameter int TEXT_ROWS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data,
  input  logic [7:0]           char_code,
  input  logic                 advance,
  input  tcc_pkg::ctl_cmd_t    cmd,
  output tcc_pkg::ctl_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           command,
  output logic [7:0]           glyph,
  output logic [7:0]           pos_x,
  output logic [7:0]           pos_y,
  output logic                 last
);

  localparam logic [7:0] EDGE_X   = 8'(8 + 8 * TEXT_COLUMNS);
  localparam logic [7:0] BOTTOM_Y = 8'(28 + 16 * (TEXT_ROWS - 1));

  logic       display_present;
  logic       indent_new_line;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] code;
  logic       adv;
  logic [2:0] body_count;

  logic [7:0] col_next;
  logic [7:0] row_next;
  logic [2:0] body_count_next;
  logic [7:0] col_stepped;
  logic [7:0] col_after_step;
  logic [7:0] line_start;
  logic [7:0] draw_glyph;
  logic       do_nl;
  logic       body_room;
  logic       emit;
  logic [1:0] e_command;
  logic [7:0] e_glyph;
  logic [7:0] e_x;
  logic [7:0] e_y;
  logic       e_last;

  assign col_stepped = col + tcc_pkg::CELL_W;
  assign line_start  = indent_new_line ? tcc_pkg::WIN_LEFT + tcc_pkg::CELL_W
                                       : tcc_pkg::WIN_LEFT;
  // column the cursor lands on when a step is taken, wrap included
  assign col_after_step = (col_stepped == EDGE_X) ? line_start : col_stepped;
  assign draw_glyph  = (code == tcc_pkg::CHAR_TAB) ? tcc_pkg::CHAR_SPACE : code;
  assign do_nl       = cmd.newline || (cmd.step && col_stepped == EDGE_X);
  assign body_room   = (body_count < tcc_pkg::BODY_MAX);

  always_comb begin
    col_next = col;
    row_next = row;
    body_count_next = cmd.load ? 3'd0 : body_count;
    emit = 1'b0;
    e_command = tcc_pkg::CMD_DRAW;
    e_glyph = 8'd0;
    e_x = col;
    e_y = row;
    e_last = 1'b0;

    if (cmd.step) col_next = col_stepped;

    if (cmd.draw && display_present && draw_glyph != tcc_pkg::CHAR_NUL && body_room) begin
      emit = 1'b1;
      e_glyph = draw_glyph;
    end

    if (do_nl) begin
      col_next = line_start;
      if (row < BOTTOM_Y) begin
        row_next = row + tcc_pkg::ROW_H;
      end else if (display_present && body_room) begin
        emit = 1'b1;
        e_command = tcc_pkg::CMD_SCROLL;
        e_x = tcc_pkg::WIN_LEFT;
        e_y = tcc_pkg::WIN_TOP;
      end
    end

    if (emit) body_count_next = body_count + 3'd1;

    if (cmd.report) begin
      emit = 1'b1;
      e_command = tcc_pkg::CMD_REPORT;
      e_last = 1'b1;
    end
  end

  assign status.in_lf    = (char_code == tcc_pkg::CHAR_LF);
  assign status.in_cr    = (char_code == tcc_pkg::CHAR_CR);
  assign status.tab      = (code == tcc_pkg::CHAR_TAB);
  assign status.adv      = adv;
  assign status.tab_stop =
    (((col_after_step - tcc_pkg::WIN_LEFT) & tcc_pkg::TAB_MASK) == 8'd0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_present <= 1'b1;
      indent_new_line <= 1'b0;
      col <= tcc_pkg::WIN_LEFT;
      row <= tcc_pkg::WIN_TOP;
      body_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tcc_pkg::CFG_DISPLAY: display_present <= cfg_data;
          tcc_pkg::CFG_INDENT:  indent_new_line <= cfg_data;
          default: ;
        endcase
      end
      col <= col_next;
      row <= row_next;
      body_count <= body_count_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload: latch the word on accept, hold the result until the next emit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code <= char_code;
      adv <= advance;
    end
    if (emit) begin
      command <= e_command;
      glyph <= e_glyph;
      pos_x <= e_x;
      pos_y <= e_y;
      last <= e_last;
    end
  end

  a_budget: assert property (@(posedge clk) disable iff (rst)
    body_count <= tcc_pkg::BODY_MAX)
    else $error("body command budget exceeded");

  a_window: assert property (@(posedge clk) disable iff (rst)
    col >= tcc_pkg::WIN_LEFT && col < EDGE_X && row >= tcc_pkg::WIN_TOP && row <= BOTTOM_Y)
    else $error("cursor outside text window");

  a_last_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> command == tcc_pkg::CMD_REPORT)
    else $error("last set on a non-report word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> status.out_free)
    else $error("result overwritten while held");

endmodule

// ===== hw/rtl/text_console_cursor.sv =====
// Text console cursor control for an 8x16-pixel cell text window.
// chars: one word per character (char_code, advance), valid/ready.
// cmds:  a run of words per character: draw glyph, scroll up one row, and
//        always a closing cursor report with last set.
// Configuration: cfg_we writes cfg_data[0] to register cfg_index
//   (0 display_present, 1 indent_new_line); write only while idle.
// One character is handled at a time; chars.ready is high only between runs.
// Each controller step (accept, draw, cursor step, new line, report) issues
// at most one word through a single output register.
// Steps per character: line feed accept, new line, report; carriage return
// accept, report; printable accept, draw, cursor step (with advance only),
// report; tab accept, then draw and cursor step per cell, then report.
// The accept issues no word; the first word of a run comes from a later step.
// A stalled receiver freezes the controller: the held word stays put and no
// step past the accept advances until it is taken.
// Reset: cursor at column 8, row 28, display on, no indent, output empty.
module text_console_cursor #(
  parameter int TEXT_COLUMNS = 30,
  parameter int TEXT_ROWS    = 8
) (
  input  logic          clk,
  input  logic          rst,
  tcc_in_if.sink        chars,
  tcc_out_if.source     cmds,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_data
);

  tcc_pkg::ctl_cmd_t    cmd;
  tcc_pkg::ctl_status_t status;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcc_datapath #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_code (chars.char_code),
    .advance   (chars.advance),
    .cmd       (cmd),
    .status    (status),
    .out_valid (cmds.valid),
    .out_ready (cmds.ready),
    .command   (cmds.command),
    .glyph     (cmds.glyph),
    .pos_x     (cmds.pos_x),
    .pos_y     (cmds.pos_y),
    .last      (cmds.last)
  );

endmodule

// ===== test/tb_text_console_cursor.sv =====
module tb_text_console_cursor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_COLUMNS = 30;
  localparam int TEXT_ROWS    = 8;
  localparam int EDGE_X       = int'(tcc_pkg::WIN_LEFT) + int'(tcc_pkg::CELL_W) * TEXT_COLUMNS;
  localparam int BOTTOM_Y     = int'(tcc_pkg::WIN_TOP) + int'(tcc_pkg::ROW_H) * (TEXT_ROWS - 1);
  localparam int TAB_CELLS    = int'(tcc_pkg::TAB_LAST_CELL) + 1;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_ITEMS  = 19;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] glyph;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       last;
  } cmd_word_t;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  // pinned rows carry the cursor report position typed in by hand
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] code;
    logic       adv;
    logic       pinned;
    logic [7:0] rep_x;
    logic [7:0] rep_y;
    logic       disp_val;
    logic       indent_val;
  } script_row_t;

  localparam int DIRECTED_ROWS = 28;
  localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_CHAR, 8'h41,             1'b1, 1'b1, 8'd16,  8'd28,  1'b0, 1'b0},
    '{ROW_CHAR, 8'hff,             1'b0, 1'b1, 8'd16,  8'd28,  1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_NUL, 1'b1, 1'b1, 8'd24,  8'd28,  1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_NUL, 1'b0, 1'b1, 8'd24,  8'd28,  1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_CR,  1'b1, 1'b1, 8'd24,  8'd28,  1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b1, 1'b1, 8'd40,  8'd28,  1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b0, 1'b1, 8'd8,   8'd44,  1'b0, 1'b0},
    '{ROW_CHAR, 8'h80,             1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    // walk down to the bottom row, then scroll
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b1, 1'b1, 8'd8,   8'd140, 1'b0, 1'b0},
    // tab across to the last cell
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0},
    '{ROW_CHAR, 8'h7a,             1'b1, 1'b1, 8'd240, 8'd140, 1'b0, 1'b0},
    // tab that wraps with indent on the bottom row fills the command budget
    '{ROW_CFG,  tcc_pkg::CHAR_NUL, 1'b0, 1'b0, 8'd0,   8'd0,   1'b1, 1'b1},
    '{ROW_CHAR, tcc_pkg::CHAR_TAB, 1'b1, 1'b1, 8'd40,  8'd140, 1'b0, 1'b0},
    // display off: scroll only tracks the cursor
    '{ROW_CFG,  tcc_pkg::CHAR_NUL, 1'b0, 1'b0, 8'd0,   8'd0,   1'b0, 1'b1},
    '{ROW_CHAR, tcc_pkg::CHAR_LF,  1'b0, 1'b1, 8'd16,  8'd140, 1'b0, 1'b0},
    '{ROW_CHAR, 8'h51,             1'b1, 1'b0, 8'd0,   8'd0,   1'b0, 1'b0}
  };

  localparam logic [RAND_PHASES-1:0] PHASE_DISP   = 4'b0101;
  localparam logic [RAND_PHASES-1:0] PHASE_INDENT = 4'b0011;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  tcc_in_if  char_bus ();
  tcc_out_if cmd_bus ();

  text_console_cursor #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .chars    (char_bus),
    .cmds     (cmd_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cursor tracker state
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic       show_display;
  logic       indent_lines;
  int         body_words;
  cmd_word_t  expected_cmds [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int ready_left = 0;

  function automatic void emit_body_word(input logic [1:0] command, input logic [7:0] glyph,
                                         input logic [7:0] x, input logic [7:0] y);
    if (body_words < int'(tcc_pkg::BODY_MAX)) begin
      expected_cmds.push_back(cmd_word_t'{command, glyph, x, y, 1'b0});
      body_words++;
    end
  endfunction

  function automatic void draw_glyph(input logic [7:0] glyph);
    if (show_display)
      emit_body_word(tcc_pkg::CMD_DRAW, glyph, cursor_col, cursor_row);
  endfunction

  function automatic void next_line();
    if (int'(cursor_row) < BOTTOM_Y)
      cursor_row = cursor_row + tcc_pkg::ROW_H;
    else if (show_display)
      emit_body_word(tcc_pkg::CMD_SCROLL, tcc_pkg::CHAR_NUL, tcc_pkg::WIN_LEFT,
                     tcc_pkg::WIN_TOP);
    cursor_col = indent_lines ? tcc_pkg::WIN_LEFT + tcc_pkg::CELL_W : tcc_pkg::WIN_LEFT;
  endfunction

  function automatic void move_right();
    cursor_col = cursor_col + tcc_pkg::CELL_W;
    if (int'(cursor_col) == EDGE_X)
      next_line();
  endfunction

  function automatic void predict_char(input logic [7:0] code, input logic adv);
    logic [7:0] offset;
    body_words = 0;
    if (code == tcc_pkg::CHAR_TAB) begin
      for (int i = 0; i < TAB_CELLS; i++) begin
        draw_glyph(tcc_pkg::CHAR_SPACE);
        move_right();
        offset = cursor_col - tcc_pkg::WIN_LEFT;
        if ((offset & tcc_pkg::TAB_MASK) == 8'd0)
          break;
      end
    end else if (code == tcc_pkg::CHAR_LF) begin
      next_line();
    end else if (code != tcc_pkg::CHAR_CR) begin
      if (code != tcc_pkg::CHAR_NUL)
        draw_glyph(code);
      if (adv)
        move_right();
    end
    expected_cmds.push_back(cmd_word_t'{tcc_pkg::CMD_REPORT, tcc_pkg::CHAR_NUL, cursor_col,
                                        cursor_row, 1'b1});
  endfunction

  task automatic note_mismatch(input string what, input cmd_word_t want, input cmd_word_t seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected cmd=%0d glyph=%02h x=%0d y=%0d last=%0b",
               $realtime, what, want.command, want.glyph, want.pos_x, want.pos_y, want.last,
               "; got cmd=%0d glyph=%02h x=%0d y=%0d last=%0b",
               seen.command, seen.glyph, seen.pos_x, seen.pos_y, seen.last);
  endtask

  task automatic push_char(input logic [7:0] code, input logic adv);
    @(negedge clk);
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= code;
    char_bus.advance   <= adv;
    @(posedge clk);
    while (!char_bus.ready)
      @(posedge clk);
    predict_char(code, adv);
  endtask

  // mostly back to back, sometimes a short gap, rarely a long one
  task automatic sender_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      gap = 0;
    else if (pick < 85)
      gap = $urandom_range(1, 3);
    else if (pick < 97)
      gap = $urandom_range(4, 10);
    else
      gap = $urandom_range(20, 60);
    if (gap > 0) begin
      @(negedge clk);
      char_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold the sender until every expected word is back and the block is idle
  task automatic drain_results();
    @(negedge clk);
    char_bus.valid <= 1'b0;
    while (expected_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic disp_val, input logic indent_val);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tcc_pkg::CFG_DISPLAY;
    cfg_data  <= disp_val;
    @(negedge clk);
    cfg_index <= tcc_pkg::CFG_INDENT;
    cfg_data  <= indent_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    show_display = disp_val;
    indent_lines = indent_val;
  endtask

  // receiver: bursts of ready and stalls of random length
  always @(negedge clk) begin
    int pick;
    if (ready_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cmd_bus.ready <= 1'b1;
        ready_left = $urandom_range(1, 8);
      end else if (pick < 85) begin
        cmd_bus.ready <= 1'b0;
        ready_left = $urandom_range(1, 3);
      end else if (pick < 95) begin
        cmd_bus.ready <= 1'b1;
        ready_left = $urandom_range(30, 80);
      end else begin
        cmd_bus.ready <= 1'b0;
        ready_left = $urandom_range(10, 40);
      end
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk) begin
    cmd_word_t seen;
    cmd_word_t want;
    if (!rst && cmd_bus.valid && cmd_bus.ready) begin
      seen = '{cmd_bus.command, cmd_bus.glyph, cmd_bus.pos_x, cmd_bus.pos_y, cmd_bus.last};
      if (expected_cmds.size() == 0) begin
        note_mismatch("unexpected word", '0, seen);
      end else begin
        want = expected_cmds.pop_front();
        if (seen.command !== want.command || seen.glyph !== want.glyph ||
            seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
            seen.last !== want.last)
          note_mismatch("word mismatch", want, seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cmd_word_t  report;
    logic [7:0] code;
    int         pick;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = tcc_pkg::CFG_DISPLAY;
    cfg_data           = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = tcc_pkg::CHAR_NUL;
    char_bus.advance   = 1'b0;
    cursor_col         = tcc_pkg::WIN_LEFT;
    cursor_row         = tcc_pkg::WIN_TOP;
    show_display       = 1'b1;
    indent_lines       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_config(DIRECTED[i].disp_val, DIRECTED[i].indent_val);
      end else begin
        push_char(DIRECTED[i].code, DIRECTED[i].adv);
        if (DIRECTED[i].pinned) begin
          report = expected_cmds.pop_back();
          report.pos_x = DIRECTED[i].rep_x;
          report.pos_y = DIRECTED[i].rep_y;
          expected_cmds.push_back(report);
        end
        sender_gap();
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_config(PHASE_DISP[p], PHASE_INDENT[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15)
          code = tcc_pkg::CHAR_TAB;
        else if (pick < 30)
          code = tcc_pkg::CHAR_LF;
        else if (pick < 35)
          code = tcc_pkg::CHAR_CR;
        else if (pick < 40)
          code = tcc_pkg::CHAR_NUL;
        else if (pick < 55)
          code = 8'($urandom_range(0, 255));
        else
          code = 8'($urandom_range(8'h21, 8'h7e));
        push_char(code, $urandom_range(0, 9) < 8);
        if ($urandom_range(0, 29) == 0)
          drain_results();
        else
          sender_gap();
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
